// ===== design/gbba_pkg.sv =====
// Package for the grouped block bitmap allocator: sizes, status codes,
// controller states and the command/status structs. No dependencies.
package gbba_pkg;

    localparam int unsigned MAX_BLOCKS_DEF = 65536;
    localparam int unsigned WORD_BITS_DEF  = 64;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DISABLED = 2'd1,
        ST_NO_SPACE = 2'd2,
        ST_INVALID  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FREE_RD,
        S_WRITE,
        S_DONE
    } t_state;

    localparam logic [2:0] REG_ENABLED = 3'd0;
    localparam logic [2:0] REG_FDB     = 3'd1;
    localparam logic [2:0] REG_GSL2    = 3'd2;
    localparam logic [2:0] REG_GCNT    = 3'd3;
    localparam logic [2:0] REG_TOTAL   = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic clr_start;  // begin clear sweep
        logic clr_step;   // write zero at sweep address, advance
        logic load;       // capture request
        logic scan_start; // set word address to first word
        logic rd;         // issue memory read
        logic scan_next;  // advance word address
        logic wr;         // write modified word, update count
        logic fin;        // produce result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic op_free;
        logic early_done; // request settled without memory access
        logic hit;        // free candidate found in current word
        logic scan_end;   // current word is the last candidate word
    } t_stat;

endpackage

// ===== design/grouped_block_bitmap_allocator.sv =====
// Top level of the grouped block bitmap allocator: APB register file and
// the controller/datapath pair. Depends on gbba_pkg, gbba_ctrl, gbba_dp.
//
// After reset the block clears its bitmap memory, one word per cycle after
// a start step, before it takes a request. An allocate reads bitmap words
// until a free bit turns up (at most 1024 words at defaults): one word is
// read and checked per cycle from the bitmap memory. A free reads its word
// and writes it back; a rejected request settles without memory access.
// One request is handled at a time; the result word waits in the output
// register until taken, and the next request is taken in the cycle after
// that at the earliest.
module grouped_block_bitmap_allocator #(
    parameter int unsigned MAX_BLOCKS       = gbba_pkg::MAX_BLOCKS_DEF,
    parameter int unsigned BITMAP_WORD_BITS = gbba_pkg::WORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic [15:0] i_block_number,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_success,
    output logic [15:0] o_granted_block,
    output logic [1:0]  o_status,
    output logic [16:0] o_free_count
);
    import gbba_pkg::*;

    logic        r_enabled;
    logic        r_fdb;
    logic [4:0]  r_gsl2;
    logic [13:0] r_gcnt;
    logic [16:0] r_total;

    assign pready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
            r_fdb     <= 1'b1;
            r_gsl2    <= 5'd13;
            r_gcnt    <= 14'd8;
            r_total   <= 17'd65536;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                REG_ENABLED: r_enabled <= pwdata[0];
                REG_FDB:     r_fdb     <= pwdata[0];
                REG_GSL2:    r_gsl2    <= pwdata[4:0];
                REG_GCNT:    r_gcnt    <= pwdata[13:0];
                REG_TOTAL:   r_total   <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (paddr[4:2])
            REG_ENABLED: prdata = 32'(r_enabled);
            REG_FDB:     prdata = 32'(r_fdb);
            REG_GSL2:    prdata = 32'(r_gsl2);
            REG_GCNT:    prdata = 32'(r_gcnt);
            REG_TOTAL:   prdata = 32'(r_total);
            default:     prdata = '0;
        endcase
    end

    t_cmd  cmd;
    t_stat stat;

    gbba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    gbba_dp #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .WORD_BITS  (BITMAP_WORD_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_operation     (i_operation),
        .i_block_number  (i_block_number),
        .i_enabled       (r_enabled),
        .i_fdb           (r_fdb),
        .i_gsl2          (r_gsl2),
        .i_gcnt          (r_gcnt),
        .i_total         (r_total),
        .o_success       (o_success),
        .o_granted_block (o_granted_block),
        .o_status        (o_status),
        .o_free_count    (o_free_count)
    );

`ifndef SYNTH
    a_ok_success: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_success == (o_status == ST_OK))) else $error("status mismatch");
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_success) |-> o_granted_block == 16'd0) else $error("grant on fail");
    a_free_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_free_count <= r_total) else $error("free count too large");
`endif
endmodule

// ===== design/gbba_ctrl.sv =====
// Controller state machine of the allocator.
// Depends on gbba_pkg.
module gbba_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    input  gbba_pkg::t_stat i_stat,
    output gbba_pkg::t_cmd  o_cmd
);
    import gbba_pkg::*;

    t_state r_state, n_state;
    logic   r_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_first <= 1'b1;
        end else begin
            r_state <= n_state;
            r_first <= 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                if (r_first) begin
                    o_cmd.clr_start = 1'b1;
                end else begin
                    o_cmd.clr_step = 1'b1;
                    if (i_stat.clr_last) n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_FREE_RD; // decided next cycle in S_FREE_RD
                end
            end
            S_FREE_RD: begin
                // request registered; dispatch
                if (i_stat.early_done) begin
                    o_cmd.fin = 1'b1;
                    n_state = S_DONE;
                end else if (i_stat.op_free) begin
                    o_cmd.rd = 1'b1;
                    n_state = S_WRITE;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                o_cmd.rd = 1'b1;
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (i_stat.hit) begin
                    o_cmd.wr  = 1'b1;
                    o_cmd.fin = 1'b1;
                    n_state = S_DONE;
                end else if (i_stat.scan_end) begin
                    o_cmd.fin = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    o_cmd.rd = 1'b1;
                end
            end
            S_WRITE: begin
                o_cmd.wr  = 1'b1;
                o_cmd.fin = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_valid = 1'b1;
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef SYNTH
    a_no_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready and valid together");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid) else $error("result dropped");
    a_wr_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr |-> o_cmd.fin) else $error("write without finish");
`endif
endmodule

// ===== design/gbba_dp.sv =====
// Datapath: bitmap memory, request registers, scan address, used count.
// Depends on gbba_pkg.
module gbba_dp #(
    parameter int unsigned MAX_BLOCKS = gbba_pkg::MAX_BLOCKS_DEF,
    parameter int unsigned WORD_BITS  = gbba_pkg::WORD_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gbba_pkg::t_cmd  i_cmd,
    output gbba_pkg::t_stat o_stat,
    input  logic            i_operation,
    input  logic [15:0]     i_block_number,
    input  logic            i_enabled,
    input  logic            i_fdb,
    input  logic [4:0]      i_gsl2,
    input  logic [13:0]     i_gcnt,
    input  logic [16:0]     i_total,
    output logic            o_success,
    output logic [15:0]     o_granted_block,
    output logic [1:0]      o_status,
    output logic [16:0]     o_free_count
);
    import gbba_pkg::*;

    localparam int unsigned WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int unsigned SW    = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int unsigned BW    = $clog2(MAX_BLOCKS) + 1;
    localparam int unsigned HW    = 32;

    logic [WORD_BITS-1:0] r_mem [WORDS];
    logic [WORD_BITS-1:0] r_rdata;
    logic [AW-1:0]        r_addr;
    logic                 r_op;
    logic [15:0]          r_blk;
    logic [HW-1:0]        r_hi;    // exclusive upper bound of candidates
    logic [16:0]          r_used;
    logic                 r_early;
    t_status              r_early_st;

    // candidate bound and free checks, from settled config
    logic [HW-1:0] n_hi_raw, n_hi;
    logic [16:0]   blk_off;
    logic [HW-1:0] grp_idx;
    logic          free_bad;

    always_comb begin
        n_hi_raw = HW'(i_fdb) + (HW'(i_gcnt) << i_gsl2);
        if (i_gsl2 > 5'd17) n_hi_raw = {HW{1'b1}};
        n_hi = n_hi_raw;
        if (n_hi > HW'(i_total)) n_hi = HW'(i_total);
        if (n_hi > HW'(MAX_BLOCKS)) n_hi = HW'(MAX_BLOCKS);
        blk_off  = 17'(i_block_number) - 17'(i_fdb);
        grp_idx  = HW'(blk_off) >> i_gsl2;
        free_bad = (i_block_number == 16'd0) || (i_block_number < 16'(i_fdb)) ||
                   (32'(i_block_number) >= 32'(MAX_BLOCKS)) || (grp_idx >= HW'(i_gcnt));
    end

    // scan window for current word
    logic [BW-1:0]        word_base;
    logic [WORD_BITS-1:0] cand;
    logic                 hit;
    logic [SW-1:0]        hit_pos;
    logic [BW-1:0]        bnum;

    always_comb begin
        word_base = BW'(r_addr) << SW;
        for (int i = 0; i < WORD_BITS; i++) begin
            bnum = word_base + BW'(i);
            cand[i] = !r_rdata[i] && (HW'(bnum) >= HW'(i_fdb)) && (HW'(bnum) < r_hi);
        end
        hit = |cand;
        hit_pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (cand[i]) hit_pos = SW'(i);
        end
        bnum = '0;
    end

    logic [HW-1:0] last_word;
    assign last_word = (r_hi == '0) ? '0 : ((r_hi - 1) >> SW);

    assign o_stat.clr_last   = (r_addr == AW'(WORDS - 1));
    assign o_stat.op_free    = r_op;
    assign o_stat.early_done = r_early;
    assign o_stat.hit        = hit;
    assign o_stat.scan_end   = (HW'(r_addr) >= last_word);

    // memory: one write, one registered read
    logic [AW-1:0]        mem_addr;
    logic [WORD_BITS-1:0] wdata;
    always_comb begin
        mem_addr = r_addr;
        if (i_cmd.scan_next) mem_addr = r_addr + AW'(1);
        wdata = r_rdata;
        if (r_op == OP_FREE) wdata[r_blk[SW-1:0]] = 1'b0;
        else                 wdata[hit_pos] = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) r_mem[r_addr] <= '0;
        else if (i_cmd.wr)  r_mem[r_addr] <= wdata;
        if (i_cmd.rd)       r_rdata <= r_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_addr <= '0;
        end else begin
            if (i_cmd.clr_start) r_addr <= '0;
            else if (i_cmd.clr_step) r_addr <= r_addr + AW'(1);
            else if (i_cmd.scan_start) r_addr <= AW'(HW'(i_fdb) >> SW);
            else if (i_cmd.scan_next) r_addr <= r_addr + AW'(1);
            else if (i_cmd.load) r_addr <= AW'(32'(i_block_number) >> SW);
            if (i_cmd.wr) begin
                if (r_op == OP_FREE) begin
                    if (r_used != 17'd0) r_used <= r_used - 17'd1;
                end else if (r_used != 17'h1FFFF) begin
                    r_used <= r_used + 17'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_blk <= i_block_number;
            r_hi  <= n_hi;
            if (!i_enabled) begin
                r_early    <= 1'b1;
                r_early_st <= ST_DISABLED;
            end else if (i_operation == OP_FREE && free_bad) begin
                r_early    <= 1'b1;
                r_early_st <= ST_INVALID;
            end else if (i_operation == OP_ALLOC && n_hi <= HW'(i_fdb)) begin
                r_early    <= 1'b1;
                r_early_st <= ST_NO_SPACE;
            end else begin
                r_early <= 1'b0;
            end
        end
    end

    // result register; free count settles after the write
    logic [16:0] used_after;
    always_comb begin
        used_after = r_used;
        if (i_cmd.wr) begin
            if (r_op == OP_FREE) begin
                if (r_used != 17'd0) used_after = r_used - 17'd1;
            end else if (r_used != 17'h1FFFF) begin
                used_after = r_used + 17'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            o_free_count <= (i_total > used_after) ? i_total - used_after : 17'd0;
            if (r_early) begin
                o_success <= 1'b0; o_granted_block <= '0; o_status <= r_early_st;
            end else if (r_op == OP_FREE) begin
                o_success <= 1'b1; o_granted_block <= '0; o_status <= ST_OK;
            end else if (hit) begin
                o_success <= 1'b1; o_status <= ST_OK;
                o_granted_block <= 16'(word_base | BW'(hit_pos));
            end else begin
                o_success <= 1'b0; o_granted_block <= '0; o_status <= ST_NO_SPACE;
            end
        end
    end

`ifndef SYNTH
    a_wr_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr && r_op == OP_ALLOC) |-> hit) else $error("alloc write without hit");
    a_cnt_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr && r_op == OP_ALLOC && $past(1'b1) && r_used != 17'h1FFFF)
        |=> r_used == $past(r_used) + 17'd1) else $error("count not raised");
    a_no_wr_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr |-> !r_early) else $error("write on rejected request");
`endif
endmodule
